>>> sv/iexp_pkg.sv
// Shared constants, types and codes of the infix expression evaluator.
package iexp_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned RESULT_W   = 32;
  localparam int unsigned EXT_W      = 64;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'h3D;
  localparam logic [3:0]        DIGIT_BASE = 4'd10;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_MUL,
    CLS_DIV,
    CLS_ADD,
    CLS_SUB,
    CLS_EQ
  } chr_cls_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DIGIT,
    ACT_CLOSE_SET,
    ACT_CLOSE_MUL,
    ACT_CLOSE_DIVZ,
    ACT_DIV_START,
    ACT_DIV_STEP,
    ACT_DIV_END,
    ACT_SET_MUL,
    ACT_SET_DIV,
    ACT_ADD_TERM,
    ACT_EMIT
  } dp_act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DIV,
    ST_DIVEND,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_act_e act;
    logic    sub;
  } dp_cmd_t;

  typedef struct packed {
    chr_cls_e cls;
    term_op_e pend_op;
    logic     operand_zero;
    logic     div_last;
  } dp_sts_t;

endpackage

>>> sv/iexp_dp.sv
// Datapath: operand entry, term and sum registers, serial divider, result register.
module iexp_dp
  import iexp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [CHAR_W-1:0]          char_in_i,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  output logic signed [RESULT_W-1:0] result_value_o,
  output logic                       div_by_zero_o
);

  logic [DATA_WIDTH-1:0] sum_q, sum_d;
  logic [DATA_WIDTH-1:0] term_q, term_d;
  logic [DATA_WIDTH-1:0] operand_q, operand_d;
  logic                  sign_q, sign_d;
  term_op_e              pend_op_q, pend_op_d;
  logic                  err_q, err_d;

  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dvs_q, dvs_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic signed [RESULT_W-1:0] res_q, res_d;
  logic                       dz_q, dz_d;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH-1:0] term_closed;
  logic [DATA_WIDTH-1:0] digit_next;
  logic signed [EXT_W-1:0] fin_ext;

  always_comb begin
    priority if (char_in_i == CHAR_SPACE) begin
      sts_o.cls = CLS_SPACE;
    end else if (char_in_i == CHAR_STAR) begin
      sts_o.cls = CLS_MUL;
    end else if (char_in_i == CHAR_SLASH) begin
      sts_o.cls = CLS_DIV;
    end else if (char_in_i == CHAR_PLUS) begin
      sts_o.cls = CLS_ADD;
    end else if (char_in_i == CHAR_MINUS) begin
      sts_o.cls = CLS_SUB;
    end else if (char_in_i == CHAR_EQUAL) begin
      sts_o.cls = CLS_EQ;
    end else begin
      sts_o.cls = CLS_DIGIT;
    end
    sts_o.pend_op      = pend_op_q;
    sts_o.operand_zero = (operand_q == '0);
    sts_o.div_last     = (cnt_q == CNT_W'(DATA_WIDTH - 1));
  end

  assign shifted     = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff        = shifted - {1'b0, dvs_q};
  assign mag_a       = term_q[DATA_WIDTH-1] ? (~term_q + 1'b1) : term_q;
  assign mag_b       = operand_q[DATA_WIDTH-1] ? (~operand_q + 1'b1) : operand_q;
  assign term_closed = sign_q ? (sum_q - term_q) : (sum_q + term_q);
  assign digit_next  = (operand_q << 3) + (operand_q << 1)
                     + DATA_WIDTH'(char_in_i) - DATA_WIDTH'(CHAR_ZERO);
  assign fin_ext     = EXT_W'(signed'(term_closed));

  always_comb begin
    sum_d     = sum_q;
    term_d    = term_q;
    operand_d = operand_q;
    sign_d    = sign_q;
    pend_op_d = pend_op_q;
    err_d     = err_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    dz_d      = dz_q;
    unique case (cmd_i.act)
      ACT_NONE: begin
      end
      ACT_DIGIT: begin
        operand_d = digit_next;
      end
      ACT_CLOSE_SET: begin
        term_d    = operand_q;
        operand_d = '0;
      end
      ACT_CLOSE_MUL: begin
        term_d    = DATA_WIDTH'(term_q * operand_q);
        operand_d = '0;
      end
      ACT_CLOSE_DIVZ: begin
        term_d    = '0;
        err_d     = 1'b1;
        operand_d = '0;
      end
      ACT_DIV_START: begin
        rem_d = '0;
        quo_d = mag_a;
        dvs_d = mag_b;
        neg_d = term_q[DATA_WIDTH-1] ^ operand_q[DATA_WIDTH-1];
        cnt_d = '0;
      end
      ACT_DIV_STEP: begin
        if (!diff[DATA_WIDTH]) begin
          rem_d = diff[DATA_WIDTH-1:0];
          quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = shifted[DATA_WIDTH-1:0];
          quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
      end
      ACT_DIV_END: begin
        term_d    = neg_q ? (~quo_q + 1'b1) : quo_q;
        operand_d = '0;
      end
      ACT_SET_MUL: begin
        pend_op_d = OP_MUL;
      end
      ACT_SET_DIV: begin
        pend_op_d = OP_DIV;
      end
      ACT_ADD_TERM: begin
        sum_d     = term_closed;
        term_d    = '0;
        pend_op_d = OP_NONE;
        sign_d    = cmd_i.sub;
      end
      ACT_EMIT: begin
        res_d     = fin_ext[RESULT_W-1:0];
        dz_d      = err_q;
        sum_d     = '0;
        term_d    = '0;
        operand_d = '0;
        sign_d    = 1'b0;
        pend_op_d = OP_NONE;
        err_d     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      term_q    <= '0;
      operand_q <= '0;
      sign_q    <= 1'b0;
      pend_op_q <= OP_NONE;
      err_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      sum_q     <= sum_d;
      term_q    <= term_d;
      operand_q <= operand_d;
      sign_q    <= sign_d;
      pend_op_q <= pend_op_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    res_q <= res_d;
    dz_q  <= dz_d;
  end

  assign result_value_o = res_q;
  assign div_by_zero_o  = dz_q;

endmodule

>>> sv/iexp_ctrl.sv
// Controller state machine: sequences each character through the datapath.
module iexp_ctrl
  import iexp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  chr_cls_e    cls_q, cls_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.cls != CLS_SPACE && sts_i.cls != CLS_DIGIT) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (sts_i.pend_op == OP_DIV && !sts_i.operand_zero) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_DIVEND;
        end
      end
      ST_DIVEND: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (cls_q != CLS_EQ || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.act   = ACT_NONE;
    cmd_o.sub   = (cls_q == CLS_SUB);
    in_stall_o  = 1'b1;
    cls_d       = cls_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cls_d = sts_i.cls;
          if (sts_i.cls == CLS_DIGIT) begin
            cmd_o.act = ACT_DIGIT;
          end
        end
      end
      ST_CLOSE: begin
        unique case (sts_i.pend_op)
          OP_MUL:  cmd_o.act = ACT_CLOSE_MUL;
          OP_DIV:  cmd_o.act = sts_i.operand_zero ? ACT_CLOSE_DIVZ : ACT_DIV_START;
          default: cmd_o.act = ACT_CLOSE_SET;
        endcase
      end
      ST_DIV: begin
        cmd_o.act = ACT_DIV_STEP;
      end
      ST_DIVEND: begin
        cmd_o.act = ACT_DIV_END;
      end
      ST_FINISH: begin
        unique case (cls_q)
          CLS_MUL: cmd_o.act = ACT_SET_MUL;
          CLS_DIV: cmd_o.act = ACT_SET_DIV;
          CLS_ADD, CLS_SUB: cmd_o.act = ACT_ADD_TERM;
          CLS_EQ: begin
            if (out_free) begin
              cmd_o.act   = ACT_EMIT;
              out_valid_d = 1'b1;
            end
          end
          default: cmd_o.act = ACT_NONE;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cls_q       <= CLS_SPACE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cls_q       <= cls_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/infix_integer_expression_evaluator.sv
// Top level of the streaming infix integer expression evaluator.
//
// Input channel: one ASCII character per beat on char_in_i, taken when
// in_valid_i is high and in_stall_o is low. Spaces are skipped, digits
// accumulate into the current operand, + - * / and = are operators.
// Output channel: one beat per '=' carrying result_value_o (32-bit two's
// complement) and div_by_zero_o, taken when out_valid_o is high and
// out_stall_i is low.
// Flow: a space or digit is handled in the idle state and the next character
// may follow at once. An operator passes the close and finish states, with
// the divider states between them when it closes a division: the 32-step
// restoring divider runs one quotient bit per cycle. A multiply is done
// combinationally into the term register. The '=' result is written to the
// output register in the finish state. That register holds it while
// out_stall_i is high and the block keeps taking characters, waiting only
// when a second result is ready before the first has left. Reset clears the
// evaluation state and the output valid, but not the divider or result data;
// the first character is taken in the cycle after reset is released.
module infix_integer_expression_evaluator
  import iexp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CHAR_W-1:0]          char_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] result_value_o,
  output logic                       div_by_zero_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  iexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iexp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_in_i      (char_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (result_value_o),
    .div_by_zero_o  (div_by_zero_o)
  );

endmodule

>>> sv/iexp_chk.sv
// Port-level checker for the expression evaluator, bound to the top level.
module iexp_chk
  import iexp_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [CHAR_W-1:0]          char_in_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [RESULT_W-1:0] result_value_o,
  input logic                       div_by_zero_o
);

  logic in_beat;
  logic is_op;

  assign in_beat = in_valid_i && !in_stall_o;
  assign is_op   = (char_in_i == CHAR_PLUS) || (char_in_i == CHAR_MINUS)
                || (char_in_i == CHAR_STAR) || (char_in_i == CHAR_SLASH)
                || (char_in_i == CHAR_EQUAL);

  a_digit_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !is_op |=> !in_stall_o)
    else $error("stall after a digit or space beat");

  a_op_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && is_op |=> in_stall_o)
    else $error("operator beat not followed by busy");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(result_value_o) && $stable(div_by_zero_o))
    else $error("stalled result beat changed");

endmodule

bind infix_integer_expression_evaluator iexp_chk u_iexp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .char_in_i      (char_in_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .div_by_zero_o  (div_by_zero_o)
);
